// File: rtl/fwdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fwdf_pkg
// shared types and constants of the fixed width decimal formatter
// ----------------------------------------------------------------------------
package fwdf_pkg;

  localparam int MAX_DIGITS = 7;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 4;
  localparam int CHAR_W  = 8;

  localparam int DIGIT_W   = 4;
  localparam int BCD_W     = DIGIT_W * MAX_DIGITS;
  localparam int LEN_W     = $clog2(MAX_DIGITS + 1);
  localparam int DIG_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  // double dabble engine: bits consumed per cycle and number of cycles
  localparam int DD_BITS  = 5;
  localparam int DD_STEPS = (VALUE_W + DD_BITS - 1) / DD_BITS;
  localparam int DD_W     = DD_STEPS * DD_BITS;
  localparam int STEP_W   = (DD_STEPS > 1) ? $clog2(DD_STEPS) : 1;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_ERR  = 8'd69;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] digit_count;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_item_t;

  // one classified request as handed from front to back
  typedef struct packed {
    logic             is_err;
    logic [LEN_W-1:0] len;
    bcd_t             digits;
  } job_t;

endpackage : fwdf_pkg
`default_nettype wire

// File: rtl/fwdf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fwdf_front
// request intake, classification and binary to bcd conversion
// ----------------------------------------------------------------------------
module fwdf_front import fwdf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  input  wire in_item_t in_data,
  output logic          in_full,
  output logic          job_push,
  output job_t          job_data,
  input  wire logic     job_full
);

  typedef enum logic [1:0] {ENG_IDLE, ENG_CONV, ENG_PUSH} eng_state_t;

  eng_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DD_W-1:0]   shift_r, shift_nxt;
  bcd_t              bcd_r, bcd_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              err_r, err_nxt;
  logic              hold_valid_r, hold_valid_nxt;
  in_item_t          hold_r, hold_nxt;

  bcd_t bcd_step;
  logic last_step;
  logic conv_done;
  logic eng_free;
  logic take_hold;
  logic in_acc;

  // shift-add-3 over several input bits, top carry dropped
  function automatic bcd_t dd_step(input bcd_t b, input logic [DD_BITS-1:0] bits);
    bcd_t             t;
    logic [BCD_W-1:0] f;
    t = b;
    for (int i = DD_BITS - 1; i >= 0; i--) begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
        if (t[d] >= digit_t'(5)) begin
          t[d] = t[d] + digit_t'(3);
        end
      end
      f = t;
      f = {f[BCD_W-2:0], bits[i]};
      t = f;
    end
    return t;
  endfunction

  assign bcd_step  = dd_step(bcd_r, shift_r[DD_W-1 -: DD_BITS]);
  assign last_step = (step_r == STEP_W'(DD_STEPS - 1));
  assign conv_done = (state_r == ENG_CONV) && last_step;
  assign job_push  = ((state_r == ENG_PUSH) || conv_done) && !job_full;
  assign eng_free  = (state_r == ENG_IDLE) || job_push;
  assign take_hold = eng_free && hold_valid_r;
  assign in_full   = hold_valid_r && !eng_free;
  assign in_acc    = in_push && !in_full;

  always_comb begin
    job_data.is_err = err_r;
    job_data.len    = len_r;
    if (state_r == ENG_PUSH) begin
      job_data.digits = bcd_r;
    end else begin
      job_data.digits = bcd_step;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    shift_nxt      = shift_r;
    bcd_nxt        = bcd_r;
    len_nxt        = len_r;
    err_nxt        = err_r;
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;

    case (state_r)
      ENG_CONV: begin
        if (!last_step) begin
          step_nxt  = step_r + STEP_W'(1);
          shift_nxt = shift_r << DD_BITS;
          bcd_nxt   = bcd_step;
        end else if (job_full) begin
          state_nxt = ENG_PUSH;
          bcd_nxt   = bcd_step;
        end
      end
      ENG_PUSH: begin
      end
      default: begin
      end
    endcase

    if (job_push) begin
      state_nxt = ENG_IDLE;
    end

    // start the held request as soon as the engine frees up
    if (take_hold) begin
      hold_valid_nxt = 1'b0;
      len_nxt        = hold_r.digit_count[LEN_W-1:0];
      err_nxt        = (hold_r.digit_count > COUNT_W'(MAX_DIGITS));
      step_nxt       = '0;
      shift_nxt      = DD_W'(hold_r.value);
      bcd_nxt        = '0;
      if (hold_r.digit_count > COUNT_W'(MAX_DIGITS)) begin
        state_nxt = ENG_PUSH;
      end else begin
        state_nxt = ENG_CONV;
      end
    end

    // zero count requests produce nothing and are dropped here
    if (in_acc && (in_data.digit_count != '0)) begin
      hold_valid_nxt = 1'b1;
      hold_nxt       = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ENG_IDLE;
      hold_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
    step_r  <= step_nxt;
    shift_r <= shift_nxt;
    bcd_r   <= bcd_nxt;
    len_r   <= len_nxt;
    err_r   <= err_nxt;
    hold_r  <= hold_nxt;
  end

endmodule : fwdf_front
`default_nettype wire

// File: rtl/fwdf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fwdf_queue
// short job queue decoupling conversion from character output
// ----------------------------------------------------------------------------
module fwdf_queue import fwdf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_data,
  output logic      valid
);

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule : fwdf_queue
`default_nettype wire

// File: rtl/fwdf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fwdf_back
// walks a job's digits out as ascii characters, one per cycle unless stalled
// ----------------------------------------------------------------------------
module fwdf_back import fwdf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      job_valid,
  input  wire job_t      job_data,
  output logic           job_pop,
  output logic           out_empty,
  output out_item_t      out_data,
  input  wire logic      out_pop
);

  logic             act_r, act_nxt;
  job_t             job_r, job_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic             can_emit;
  logic             is_last;
  logic             finishing;
  logic [LEN_W-1:0] dig_pos;
  digit_t           cur_digit;
  out_item_t        cur_item;

  assign can_emit  = !out_valid_r || out_pop;
  assign is_last   = job_r.is_err || (pos_r == job_r.len - LEN_W'(1));
  assign finishing = act_r && can_emit && is_last;
  assign job_pop   = job_valid && (!act_r || finishing);

  // most significant requested digit first
  assign dig_pos   = job_r.len - LEN_W'(1) - pos_r;
  assign cur_digit = job_r.digits[dig_pos[DIG_IDX_W-1:0]];

  always_comb begin
    cur_item.last = is_last;
    if (job_r.is_err) begin
      cur_item.character = ASCII_ERR;
    end else begin
      cur_item.character = CHAR_W'(cur_digit) + ASCII_ZERO;
    end
  end

  always_comb begin
    act_nxt       = act_r;
    job_nxt       = job_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (act_r && can_emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = cur_item;
      pos_nxt       = pos_r + LEN_W'(1);
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end

    if (job_pop) begin
      act_nxt = 1'b1;
      job_nxt = job_data;
      pos_nxt = '0;
    end else if (finishing) begin
      act_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r <= job_nxt;
    pos_r <= pos_nxt;
    out_r <= out_nxt;
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

endmodule : fwdf_back
`default_nettype wire

// File: rtl/fixed_width_decimal_formatter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_width_decimal_formatter_unit
// 32-bit binary to fixed width ascii decimal, leading zeros, msd first
// ----------------------------------------------------------------------------
// the first character of a digit request passes through the hold register,
//   the double dabble steps, the job load and the output register
// the double dabble engine consumes 5 value bits a cycle; a new request can
//   wait in hold register meanwhile; output runs 1 char/cycle unless stalled
// error requests skip conversion; zero count requests are dropped on entry
// reset: synchronous active low rst_n clears the state, valid and pointer
//   registers; queue slots and other payload registers are not cleared
// ----------------------------------------------------------------------------
module fixed_width_decimal_formatter_unit import fwdf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  // request side
  input  wire logic      in_push,
  input  wire in_item_t  in_data,
  output logic           in_full,
  // character side
  output logic           out_empty,
  output out_item_t      out_data,
  input  wire logic      out_pop
);

  // front to queue
  logic job_push;
  job_t job_push_data;
  logic job_full;

  // queue to back
  logic job_pop;
  job_t job_pop_data;
  logic job_valid;

  // front: holds one request while the engine converts the previous one,
  // classifies it (error or digits) and produces the packed bcd digits
  fwdf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .job_push (job_push),
    .job_data (job_push_data),
    .job_full (job_full)
  );

  // short queue so conversion of the next request overlaps output of this one
  fwdf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_push_data),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_pop_data),
    .valid     (job_valid)
  );

  // back: picks digits msd first into a registered output stage; the next
  // job is taken in the cycle the last character of the current one enters it
  fwdf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_data  (job_pop_data),
    .job_pop   (job_pop),
    .out_empty (out_empty),
    .out_data  (out_data),
    .out_pop   (out_pop)
  );

endmodule : fixed_width_decimal_formatter_unit
`default_nettype wire

// File: tb/fixed_width_decimal_formatter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_width_decimal_formatter_unit_tb
// self-checking bench: value and digit count in, ascii decimal characters out
// ----------------------------------------------------------------------------
// every accepted request is expanded into its expected characters
// (msd first, leading zeros, 'E' for an oversized count, nothing for zero).
// every popped character is compared with the oldest expected one.
// stimulus: a directed set of corner requests, then random requests under
// several sender/receiver idling mixes, then a long receiver hold-off
// that backs the unit up until it refuses new requests
// ----------------------------------------------------------------------------
module fixed_width_decimal_formatter_unit_tb;
  import fwdf_pkg::*;

  localparam int HALF_PERIOD     = 10;
  localparam int RESET_CYCLES    = 12;
  localparam int ITEMS_PER_PHASE = 30;
  localparam int PRESSURE_ITEMS  = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  // leave plenty of room for stray characters to show up
  localparam int TAIL_CYCLES     = 40;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int COUNT_MAX       = (1 << COUNT_W) - 1;

  // expected characters in arrival order, plus the mismatch tally
  class char_ledger;
    out_item_t   pending_chars[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // expand one accepted request into the characters it must produce
    function void note_request(in_item_t req);
      logic [VALUE_W-1:0] shifted;
      out_item_t          ch;
      int                 n;
      n = int'(req.digit_count);
      if (n == 0) return;
      if (n > MAX_DIGITS) begin
        ch.character = ASCII_ERR;
        ch.last      = 1'b1;
        pending_chars.push_back(ch);
        return;
      end
      for (int k = 0; k < n; k++) begin
        shifted = req.value;
        for (int p = 0; p < n - 1 - k; p++) shifted = shifted / 10;
        ch.character = ASCII_ZERO + CHAR_W'(shifted % 10);
        ch.last      = (k == n - 1);
        pending_chars.push_back(ch);
      end
    endfunction

    function void check_char(out_item_t got);
      out_item_t want;
      if (pending_chars.size() == 0) begin
        $error("unexpected character %0d last %0b", got.character, got.last);
        mismatches++;
        return;
      end
      want = pending_chars.pop_front();
      if (got.character !== want.character) begin
        $error("character: expected %0d, actual %0d", want.character, got.character);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_push;
  in_item_t  in_data;
  logic      in_full;
  logic      out_empty;
  out_item_t out_data;
  logic      out_pop;

  char_ledger ledger;

  // idling mix, changed per phase by the stimulus process
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // one-shot request for a long receiver hold-off
  bit hold_off_pending = 1'b0;
  int cycle_count = 0;

  fixed_width_decimal_formatter_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_data  (out_data),
    .out_pop   (out_pop)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // watchdog: a hung unit or a lost character ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // request side monitor: pre-edge values decide acceptance
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) ledger.note_request(in_data);
  end

  // character side monitor
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) ledger.check_char(out_data);
  end

  // receiver: random stalls, or one long hold-off when asked for
  initial begin : receiver
    out_pop = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_pop <= ($urandom_range(99) >= recv_stall_pct);
        @(posedge clk);
      end
    end
  end

  function automatic in_item_t request(logic [VALUE_W-1:0] value, int count);
    in_item_t req;
    req.value       = value;
    req.digit_count = COUNT_W'(count);
    return req;
  endfunction

  // mostly digit requests, some dropped and some oversized counts;
  // values mix full range, in-range, near powers of ten and tiny ones
  function automatic in_item_t random_request();
    in_item_t           req;
    int unsigned        pick;
    logic [VALUE_W-1:0] power;
    pick = $urandom_range(99);
    if (pick < 8) begin
      req.digit_count = '0;
    end else if (pick < 18) begin
      req.digit_count = COUNT_W'($urandom_range(COUNT_MAX, MAX_DIGITS + 1));
    end else begin
      req.digit_count = COUNT_W'($urandom_range(MAX_DIGITS, 1));
    end
    case ($urandom_range(3))
      0: req.value = $urandom;
      1: req.value = $urandom_range(9999999);
      2: begin
        power = 1;
        repeat ($urandom_range(9)) power = power * 10;
        // one below, at, or one above the power of ten
        req.value = power + $urandom_range(2) - 1;
      end
      default: req.value = $urandom_range(99);
    endcase
    return req;
  endfunction

  // hold the request until the unit takes it, then maybe idle a while;
  // in_push stays high straight into the next request when not idling
  task automatic offer_request(input in_item_t req);
    in_data <= req;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic run_directed();
    // zero count: dropped, no character
    offer_request(request('0, 0));
    offer_request(request('1, 0));
    // all-ones value at every legal width, upper digits dropped
    for (int c = 1; c <= MAX_DIGITS; c++) offer_request(request('1, c));
    // full width corners
    offer_request(request(32'd0, MAX_DIGITS));
    offer_request(request(32'd1234567, MAX_DIGITS));
    offer_request(request(32'd9999999, MAX_DIGITS));
    // top digit also reduced modulo ten
    offer_request(request(32'd10000000, MAX_DIGITS));
    offer_request(request(32'd1999999, 6));
    // oversized counts: single error character
    offer_request(request(32'd0, MAX_DIGITS + 1));
    offer_request(request('1, COUNT_MAX));
    offer_request(request(32'd42, 9));
    // single digit edges
    offer_request(request(32'd9, 1));
    offer_request(request(32'd10, 1));
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct);
    in_item_t req;
    int       counted;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    counted        = 0;
    // dropped zero-count requests do not count toward the phase
    while (counted < ITEMS_PER_PHASE) begin
      req = random_request();
      offer_request(req);
      if (req.digit_count != 0) counted++;
    end
  endtask

  // receiver holds off while the sender keeps pushing full width requests,
  // so the unit backs up and raises in_full
  task automatic run_pressure();
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_off_pending = 1'b1;
    repeat (PRESSURE_ITEMS) offer_request(request($urandom, MAX_DIGITS));
  endtask

  initial begin : stimulus
    ledger  = new();
    rst_n   = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    // no idling, sender idling, receiver stalling, both
    run_random_phase(0, 0);
    run_random_phase(52, 0);
    run_random_phase(0, 52);
    run_random_phase(16, 16);
    run_pressure();
    in_push <= 1'b0;

    // drain, then give stray characters a chance to show up
    while (ledger.pending_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/fwdf_pkg.sv
rtl/fwdf_front.sv
rtl/fwdf_queue.sv
rtl/fwdf_back.sv
rtl/fixed_width_decimal_formatter_unit.sv
tb/fixed_width_decimal_formatter_unit_tb.sv
